// ----- rtl/cdt_pkg.sv -----
// shared types, codes and constants for the countdown timer
package cdt_pkg;

   localparam int FUNC_W    = 3;
   localparam int HOURS_W   = 7;
   localparam int MINUTES_W = 6;
   localparam int SECONDS_W = 6;
   localparam int STATE_W   = 2;
   localparam int REM_W     = 29;

   localparam int HOURS_MAX_DEF = 99;
   localparam int MIN_SEC_MAX   = 59;
   localparam int MS_PER_HOUR   = 3600 * 1000;
   localparam int MS_PER_MINUTE = 60 * 1000;
   localparam int MS_PER_SECOND = 1000;

   localparam logic [REM_W-1:0] REM_MAX = {REM_W{1'b1}};

   localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_START  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PAUSE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd4;

   localparam logic [STATE_W-1:0] ST_IDLE    = 2'd0;
   localparam logic [STATE_W-1:0] ST_SET     = 2'd1;
   localparam logic [STATE_W-1:0] ST_RUNNING = 2'd2;
   localparam logic [STATE_W-1:0] ST_PAUSED  = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [REM_W-1:0]  duration;
   } cmd_type;

   typedef struct packed {
      logic [STATE_W-1:0] timer_state;
      logic [REM_W-1:0]   remaining_ms;
      logic               done_res;
   } result_type;

endpackage

// ----- rtl/cdt_dur.sv -----
// duration in milliseconds from clamped hours, minutes and seconds
module cdt_dur
   import cdt_pkg::*;
#(
   parameter int HOURS_MAX = HOURS_MAX_DEF
) (
   input  logic [HOURS_W-1:0]   hours,
   input  logic [MINUTES_W-1:0] minutes,
   input  logic [SECONDS_W-1:0] seconds,
   output logic [REM_W-1:0]     duration
);

   logic [HOURS_W-1:0]   hours_c;
   logic [MINUTES_W-1:0] minutes_c;
   logic [SECONDS_W-1:0] seconds_c;
   logic [33:0]          total;

   always_comb begin
      hours_c   = (32'(hours) > 32'(HOURS_MAX)) ? HOURS_W'(HOURS_MAX) : hours;
      minutes_c = (32'(minutes) > 32'(MIN_SEC_MAX)) ? MINUTES_W'(MIN_SEC_MAX) : minutes;
      seconds_c = (32'(seconds) > 32'(MIN_SEC_MAX)) ? SECONDS_W'(MIN_SEC_MAX) : seconds;
      total     = 34'(hours_c) * 34'(MS_PER_HOUR)
                + 34'(minutes_c) * 34'(MS_PER_MINUTE)
                + 34'(seconds_c) * 34'(MS_PER_SECOND);
      duration  = (total > 34'(REM_MAX)) ? REM_MAX : total[REM_W-1:0];
   end

endmodule

// ----- rtl/cdt_core.sv -----
// timer mode and remaining count, next state and result per command
module cdt_core
   import cdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output result_type result
);

   logic [STATE_W-1:0] mode_ff, mode_in;
   logic [REM_W-1:0]   remaining_ff, remaining_in;
   logic               done;

   always_comb begin
      mode_in      = mode_ff;
      remaining_in = remaining_ff;
      done         = 1'b0;
      case (cmd.func)
         FUNC_TICK: begin
            if (mode_ff == ST_RUNNING) begin
               if (remaining_ff != '0) begin
                  remaining_in = remaining_ff - REM_W'(1);
               end
               if (remaining_ff <= REM_W'(1)) begin
                  mode_in = ST_IDLE;
                  done    = 1'b1;
               end
            end
         end
         FUNC_SET: begin
            if (mode_ff != ST_RUNNING && mode_ff != ST_PAUSED) begin
               remaining_in = cmd.duration;
               mode_in      = (cmd.duration != '0) ? ST_SET : ST_IDLE;
            end
         end
         FUNC_START: begin
            if (remaining_ff != '0) begin
               mode_in = ST_RUNNING;
            end
         end
         FUNC_PAUSE: begin
            if (mode_ff == ST_RUNNING) begin
               mode_in = ST_PAUSED;
            end
         end
         FUNC_CANCEL: begin
            remaining_in = '0;
            mode_in      = ST_IDLE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ST_IDLE;
         remaining_ff <= '0;
      end else if (cmd_valid) begin
         mode_ff      <= mode_in;
         remaining_ff <= remaining_in;
      end
   end

   assign result.timer_state  = mode_in;
   assign result.remaining_ms = remaining_in;
   assign result.done_res     = done;

endmodule

// ----- rtl/countdown_timer_core.sv -----
// countdown timer top level: input register, timer logic, result register
// a request is registered in the input register, then its result in the result register
// throughput: one request per cycle; input and result registers advance together
// a stalled response holds the whole two-stage pipe
// reset (synchronous, active high) clears mode to idle, count to zero, valids low
module countdown_timer_core
   import cdt_pkg::*;
#(
   parameter int HOURS_MAX = HOURS_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [HOURS_W-1:0]   req_hours,
   input  logic [MINUTES_W-1:0] req_minutes,
   input  logic [SECONDS_W-1:0] req_seconds,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATE_W-1:0]   rsp_timer_state,
   output logic [REM_W-1:0]     rsp_remaining_ms,
   output logic                 rsp_done_res
);

   logic                 advance;
   logic                 in_valid_ff;
   logic [FUNC_W-1:0]    in_func_ff;
   logic [HOURS_W-1:0]   in_hours_ff;
   logic [MINUTES_W-1:0] in_minutes_ff;
   logic [SECONDS_W-1:0] in_seconds_ff;
   logic                 out_valid_ff;
   result_type           out_ff;
   result_type           result;
   cmd_type              cmd;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_valid;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_func_ff    <= req_func;
         in_hours_ff   <= req_hours;
         in_minutes_ff <= req_minutes;
         in_seconds_ff <= req_seconds;
         out_ff        <= result;
      end
   end

   cdt_dur #(
      .HOURS_MAX (HOURS_MAX)
   ) u_dur (
      .hours    (in_hours_ff),
      .minutes  (in_minutes_ff),
      .seconds  (in_seconds_ff),
      .duration (cmd.duration)
   );

   assign cmd.func = in_func_ff;

   cdt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (in_valid_ff && advance),
      .cmd       (cmd),
      .result    (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_timer_state  = out_ff.timer_state;
   assign rsp_remaining_ms = out_ff.remaining_ms;
   assign rsp_done_res     = out_ff.done_res;

endmodule

// ----- rtl/cdt_checker.sv -----
// port-level checks for the countdown timer, bound to the top level
module cdt_checker
   import cdt_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [STATE_W-1:0]   rsp_timer_state,
   input logic [REM_W-1:0]     rsp_remaining_ms,
   input logic                 rsp_done_res
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_timer_state)
         && $stable(rsp_remaining_ms) && $stable(rsp_done_res))
      else $error("stalled response changed");

   // done ends in idle with an empty count
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_timer_state == ST_IDLE && rsp_remaining_ms == '0)
      else $error("done without idle and zero count");

   // set, running and paused always carry time
   a_busy_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timer_state != ST_IDLE |-> rsp_remaining_ms != '0)
      else $error("non-idle state with zero count");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // no request transfer while the result stage is full and stalled
   a_req_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response stalled");

endmodule

bind countdown_timer_core cdt_checker u_cdt_checker (.*);
